FILE: hw/rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int SlotW = 4;
  localparam int ElemW = 32;
  localparam int CmdW  = 3;
  localparam int CapW  = 5;
  localparam int StatW = 2;
  localparam int SlotLimit = 16;
  localparam int OutDataW = ((SlotW + ElemW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_DISPLAY    = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    STEP_NEXT = 1'b0,
    STEP_PREV = 1'b1
  } step_dir_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_PREV,
    S_PUSH,
    S_POP,
    S_SHOW_RD,
    S_SHOW,
    S_ERR
  } state_e;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] wslot;
    logic [ElemW-1:0] wdata;
    logic             re;
    logic [SlotW-1:0] rslot;
  } ram_req_t;

endpackage

FILE: hw/rtl/circular_deque_top.sv
// Circular deque top level: sequencer, pointers, result register.
`timescale 1ns / 1ps

// Double-ended queue in a ring store of up to 16 slots in use. One command is
// taken at a time on s_axis; results leave on m_axis through a result
// register, so the next command is taken while a result still waits. A push
// rear, pop or error goes through decode and then its result state, which
// loads the result register; a push front to a non-empty queue first steps
// back from the front slot in a state of its own. Display reads its first
// element in decode and each further element in a read state between results.
// The next command can be taken in the same cycle as the last result is presented.
// The registered read port of the store and the single shared slot stepper set
// this sequence, and a result held in the register stalls the sequencer until
// m_axis takes it. A write on the cfg channel sets the capacity (0 acts as 1,
// values above the built depth or 16 are clamped) and empties the queue; it is
// taken only when the block is idle. No clearing pass is needed after reset.
module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ElemW-1:0]    s_axis_tdata,   // [31:0] push_value
  input  logic [CmdW-1:0]     s_axis_tuser,   // [2:0] command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] slot, [35:4] element, rest zero
  output logic [StatW-1:0]    m_axis_tuser,   // [1:0] status
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CapW-1:0]     cfg_data_i
);

  localparam int CapMax = (DEPTH < SlotLimit) ? DEPTH : SlotLimit;

  state_e state_q, state_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [ElemW-1:0] val_q, val_d;
  logic [SlotW-1:0] slot_q, slot_d;
  status_e          err_q, err_d;
  logic [SlotW-1:0] front_q, front_d;
  logic [SlotW-1:0] rear_q, rear_d;
  logic             empty_q, empty_d;
  logic [CapW-1:0]  cap_q, cap_d;

  logic             m_valid_q, m_valid_d;
  status_e          m_stat_q, m_stat_d;
  logic [SlotW-1:0] m_slot_q, m_slot_d;
  logic [ElemW-1:0] m_elem_q, m_elem_d;
  logic             m_last_q, m_last_d;

  logic             out_free;
  logic             in_acc;
  logic             cfg_acc;
  logic             emit;
  logic             full;
  logic             show_last;
  logic [SlotW-1:0] step_slot;
  step_dir_e        step_dir;
  logic [SlotW-1:0] step_res;
  ram_req_t         ram_req;
  logic [ElemW-1:0] ram_rdata;

  cdq_step u_step (
    .slot_i (step_slot),
    .dir_i  (step_dir),
    .cap_i  (cap_q),
    .slot_o (step_res)
  );

  cdq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !m_valid_q || m_axis_tready;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign cfg_acc   = cfg_valid_i && cfg_ready_o;
  assign full      = !empty_q && (step_res == front_q);
  assign show_last = (slot_q == rear_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_DECODE;
      S_DECODE: begin
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (full) state_d = S_ERR;
            else if (!empty_q && cmd_q == CMD_PUSH_FRONT) state_d = S_PUSH_PREV;
            else state_d = S_PUSH;
          end
          CMD_POP_FRONT, CMD_POP_REAR: state_d = empty_q ? S_ERR : S_POP;
          CMD_DISPLAY: state_d = empty_q ? S_ERR : S_SHOW;
          default: state_d = S_IDLE;
        endcase
      end
      S_PUSH_PREV: state_d = S_PUSH;
      S_PUSH, S_POP, S_ERR: if (out_free) state_d = S_IDLE;
      S_SHOW: if (out_free) state_d = show_last ? S_IDLE : S_SHOW_RD;
      S_SHOW_RD: state_d = S_SHOW;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    val_d     = val_q;
    slot_d    = slot_q;
    err_d     = err_q;
    front_d   = front_q;
    rear_d    = rear_q;
    empty_d   = empty_q;
    cap_d     = cap_q;
    step_slot = slot_q;
    step_dir  = STEP_NEXT;
    ram_req   = '0;
    emit      = 1'b0;
    m_stat_d  = m_stat_q;
    m_slot_d  = m_slot_q;
    m_elem_d  = m_elem_q;
    m_last_d  = m_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = s_axis_tuser;
          val_d = s_axis_tdata;
        end
        if (cfg_acc) begin
          if (cfg_data_i == '0) cap_d = CapW'(1);
          else if (cfg_data_i > CapW'(CapMax)) cap_d = CapW'(CapMax);
          else cap_d = cfg_data_i;
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end
      end
      S_DECODE: begin
        step_slot = rear_q;
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            err_d  = STAT_FULL;
            slot_d = empty_q ? '0 : step_res;
          end
          CMD_POP_FRONT, CMD_POP_REAR: begin
            err_d       = STAT_EMPTY;
            slot_d      = (cmd_q == CMD_POP_FRONT) ? front_q : rear_q;
            ram_req.re  = !empty_q;
            ram_req.rslot = slot_d;
          end
          CMD_DISPLAY: begin
            err_d       = STAT_EMPTY;
            slot_d      = front_q;
            ram_req.re  = !empty_q;
            ram_req.rslot = front_q;
          end
          default: err_d = err_q;
        endcase
      end
      S_PUSH_PREV: begin
        step_slot = front_q;
        step_dir  = STEP_PREV;
        slot_d    = step_res;
      end
      S_PUSH: begin
        if (out_free) begin
          emit          = 1'b1;
          ram_req.we    = 1'b1;
          ram_req.wslot = slot_q;
          ram_req.wdata = val_q;
          m_stat_d = STAT_OK;
          m_slot_d = slot_q;
          m_elem_d = '0;
          m_last_d = 1'b1;
          if (empty_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b0;
          end else if (cmd_q == CMD_PUSH_FRONT) begin
            front_d = slot_q;
          end else begin
            rear_d = slot_q;
          end
        end
      end
      S_POP: begin
        step_dir = (cmd_q == CMD_POP_FRONT) ? STEP_NEXT : STEP_PREV;
        if (out_free) begin
          emit     = 1'b1;
          m_stat_d = STAT_OK;
          m_slot_d = slot_q;
          m_elem_d = ram_rdata;
          m_last_d = 1'b1;
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b1;
          end else if (cmd_q == CMD_POP_FRONT) begin
            front_d = step_res;
          end else begin
            rear_d = step_res;
          end
        end
      end
      S_SHOW: begin
        if (out_free) begin
          emit     = 1'b1;
          m_stat_d = STAT_OK;
          m_slot_d = slot_q;
          m_elem_d = ram_rdata;
          m_last_d = show_last;
          slot_d   = step_res;
        end
      end
      S_SHOW_RD: begin
        ram_req.re    = 1'b1;
        ram_req.rslot = slot_q;
      end
      S_ERR: begin
        if (out_free) begin
          emit     = 1'b1;
          m_stat_d = err_q;
          m_slot_d = '0;
          m_elem_d = '0;
          m_last_d = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase

    if (emit) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
    else m_valid_d = m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      rear_q    <= '0;
      empty_q   <= 1'b1;
      cap_q     <= CapW'(CapMax);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      rear_q    <= rear_d;
      empty_q   <= empty_d;
      cap_q     <= cap_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    slot_q   <= slot_d;
    err_q    <= err_d;
    m_stat_q <= m_stat_d;
    m_slot_q <= m_slot_d;
    m_elem_q <= m_elem_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_stat_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = OutDataW'({m_elem_q, m_slot_q});

  a_empty_ptrs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (front_q == '0) && (rear_q == '0))
    else $error("empty queue with nonzero pointers");

  a_ptrs_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, front_q} < cap_q) && ({1'b0, rear_q} < cap_q))
    else $error("pointer outside ring in use");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) && out_free && !cfg_acc |=> !empty_q)
    else $error("queue empty after push");

  a_error_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_stat_q != STAT_OK) |-> (m_slot_q == '0) && (m_elem_q == '0) && m_last_q)
    else $error("error result with payload");

endmodule

FILE: hw/rtl/cdq_ram.sv
// Ring store: one write port and one registered read port.
`timescale 1ns / 1ps

module cdq_ram
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  ram_req_t         req_i,
  output logic [ElemW-1:0] rdata_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ElemW-1:0] mem [DEPTH];
  logic [ElemW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[AddrW'(req_i.wslot)] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[AddrW'(req_i.rslot)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cdq_step.sv
// Shared slot stepper: next or previous slot around the ring in use.
`timescale 1ns / 1ps

module cdq_step
  import cdq_pkg::*;
(
  input  logic [SlotW-1:0] slot_i,
  input  step_dir_e        dir_i,
  input  logic [CapW-1:0]  cap_i,
  output logic [SlotW-1:0] slot_o
);

  logic [CapW-1:0] inc;
  logic [CapW-1:0] cap_m1;

  assign inc    = {1'b0, slot_i} + CapW'(1);
  assign cap_m1 = cap_i - CapW'(1);

  always_comb begin
    case (dir_i)
      STEP_NEXT: slot_o = (inc >= cap_i) ? '0 : inc[SlotW-1:0];
      STEP_PREV: slot_o = (slot_i == '0) ? cap_m1[SlotW-1:0] : slot_i - SlotW'(1);
      default:   slot_o = slot_i;
    endcase
  end

endmodule

FILE: tb/circular_deque_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_top: directed and random deque traffic.
module circular_deque_top_tb;
  import cdq_pkg::*;

  localparam int RingDepth    = 16;
  localparam int ClkPeriod    = 12;
  localparam int SettleCycles = 40;
  localparam int StallLimit   = 5000;
  localparam int PhaseItems   = 70;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ElemW-1:0] value;
  } deque_cmd_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [ElemW-1:0] element;
    logic             last;
  } deque_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ElemW-1:0]    s_axis_tdata  = '0;  // [31:0] push_value
  logic [CmdW-1:0]     s_axis_tuser  = '0;  // [2:0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [3:0] slot, [35:4] element, rest zero
  logic [StatW-1:0]    m_axis_tuser;        // [1:0] status
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CapW-1:0]     cfg_data_i    = '0;

  deque_cmd_t    pending_cmds[$];
  deque_result_t expected_results[$];
  deque_cmd_t    driven_cmd;
  int unsigned   send_idle_pct = 22;
  int unsigned   recv_idle_pct = 78;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles = 0;

  logic [ElemW-1:0] ring_mem [RingDepth] = '{default: '0};
  logic [SlotW-1:0] front_ptr   = '0;
  logic [SlotW-1:0] rear_ptr    = '0;
  logic             deque_empty = 1'b1;
  int unsigned      ring_size   = 16;

  circular_deque_top #(
    .DEPTH(RingDepth)
  ) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic logic [SlotW-1:0] slot_after(logic [SlotW-1:0] s);
    return (s + 1 >= ring_size) ? '0 : SlotW'(s + 1);
  endfunction

  function automatic logic [SlotW-1:0] slot_before(logic [SlotW-1:0] s);
    return (s == 0) ? SlotW'(ring_size - 1) : SlotW'(s - 1);
  endfunction

  function automatic void expect_result(status_e st, logic [SlotW-1:0] s,
                                        logic [ElemW-1:0] e, logic l);
    expected_results.push_back('{status: st, slot: s, element: e, last: l});
  endfunction

  function automatic void predict_command(deque_cmd_t c);
    logic [SlotW-1:0] s;
    int unsigned n;
    case (c.command)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (!deque_empty && slot_after(rear_ptr) == front_ptr) begin
          expect_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          if (deque_empty) begin
            front_ptr   = '0;
            rear_ptr    = '0;
            deque_empty = 1'b0;
            s = '0;
          end else if (c.command == CMD_PUSH_FRONT) begin
            front_ptr = slot_before(front_ptr);
            s = front_ptr;
          end else begin
            rear_ptr = slot_after(rear_ptr);
            s = rear_ptr;
          end
          ring_mem[s] = c.value;
          expect_result(STAT_OK, s, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (deque_empty) begin
          expect_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          s = (c.command == CMD_POP_FRONT) ? front_ptr : rear_ptr;
          expect_result(STAT_OK, s, ring_mem[s], 1'b1);
          if (front_ptr == rear_ptr) begin
            front_ptr   = '0;
            rear_ptr    = '0;
            deque_empty = 1'b1;
          end else if (c.command == CMD_POP_FRONT) begin
            front_ptr = slot_after(front_ptr);
          end else begin
            rear_ptr = slot_before(rear_ptr);
          end
        end
      end
      CMD_DISPLAY: begin
        if (deque_empty) begin
          expect_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          s = front_ptr;
          n = 0;
          while (s != rear_ptr && n + 1 < ring_size) begin
            expect_result(STAT_OK, s, ring_mem[s], 1'b0);
            n++;
            s = slot_after(s);
          end
          expect_result(STAT_OK, rear_ptr, ring_mem[rear_ptr], 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // Sender: hold a transaction until accepted, then advance the pending queue.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_command(driven_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_cmd = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= driven_cmd.value;
          s_axis_tuser  <= driven_cmd.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    deque_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d slot %0d element %0h last %0b",
                 m_axis_tuser, m_axis_tdata[SlotW-1:0],
                 m_axis_tdata[SlotW+ElemW-1:SlotW], m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata[SlotW-1:0] !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, m_axis_tdata[SlotW-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[SlotW+ElemW-1:SlotW] !== want.element) begin
            $error("element: expected %0h, actual %0h", want.element,
                   m_axis_tdata[SlotW+ElemW-1:SlotW]);
            mismatch_count++;
          end
          if (m_axis_tdata[OutDataW-1:SlotW+ElemW] !== '0) begin
            $error("padding: expected 0, actual %0h", m_axis_tdata[OutDataW-1:SlotW+ElemW]);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void add_cmd(logic [CmdW-1:0] c, logic [ElemW-1:0] v);
    pending_cmds.push_back('{command: c, value: v});
  endfunction

  function automatic deque_cmd_t random_cmd(int unsigned push_pct);
    deque_cmd_t c;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) begin
      c.command = CmdW'($urandom_range(CMD_DISPLAY + 1, (1 << CmdW) - 1));
    end else if (r < 12) begin
      c.command = CMD_DISPLAY;
    end else if ($urandom_range(99) < push_pct) begin
      c.command = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else begin
      c.command = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    end
    case ($urandom_range(7))
      0:       c.value = 32'h8000_0000;
      1:       c.value = 32'h7FFF_FFFF;
      2:       c.value = 32'hFFFF_FFFF;
      default: c.value = $urandom;
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] v);
    int unsigned c;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    c = (v == 0) ? 1 : v;
    if (c > RingDepth) c = RingDepth;
    if (c > SlotLimit) c = SlotLimit;
    ring_size   = c;
    front_ptr   = '0;
    rear_ptr    = '0;
    deque_empty = 1'b1;
    @(negedge clk_i);
  endtask

  // Alternate push-heavy and pop-heavy bursts; drain once midway.
  task automatic run_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained();
      pending_cmds.push_back(random_cmd(((k / 16) % 2) ? 25 : 75));
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_cmd(CMD_POP_FRONT, '0);
    add_cmd(CMD_POP_REAR, '0);
    add_cmd(CMD_DISPLAY, '0);
    add_cmd(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    add_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    add_cmd(CMD_PUSH_REAR, 32'h0000_0000);
    add_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    add_cmd(CMD_DISPLAY, '0);
    add_cmd(CMD_POP_FRONT, '0);
    add_cmd(CMD_POP_REAR, '0);
    add_cmd(CMD_DISPLAY, '0);
    add_cmd(CMD_POP_REAR, '0);
    add_cmd(CMD_POP_FRONT, '0);
    add_cmd(CMD_POP_FRONT, '0);
    for (int c = CMD_DISPLAY + 1; c < (1 << CmdW); c++) add_cmd(CmdW'(c), 32'hFFFF_FFFF);
    add_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    add_cmd(CMD_PUSH_REAR, 32'h5555_5555);
    add_cmd(CMD_POP_REAR, '0);
    add_cmd(CMD_POP_REAR, '0);
    add_cmd(CMD_DISPLAY, '0);
    wait_drained();

    set_capacity(5'd1);
    add_cmd(CMD_PUSH_REAR, 32'h1234_5678);
    add_cmd(CMD_PUSH_FRONT, 32'h1);
    add_cmd(CMD_PUSH_REAR, 32'h2);
    add_cmd(CMD_DISPLAY, '0);
    add_cmd(CMD_POP_FRONT, '0);
    run_random(PhaseItems);

    send_idle_pct = 78;
    recv_idle_pct = 22;
    set_capacity(5'd31);
    run_random(PhaseItems);
    set_capacity(5'd0);
    run_random(PhaseItems);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(CapW'($urandom_range(2, 15)));
    run_random(PhaseItems);
    set_capacity(5'd16);
    repeat (17) add_cmd(CMD_PUSH_REAR, $urandom);
    add_cmd(CMD_DISPLAY, '0);
    run_random(PhaseItems);

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
